### sv/deferred_work_deadline_table_assert.svh
// Assertion macros shared by the checker of the deferred-work deadline table.
`ifndef DEFERRED_WORK_DEADLINE_TABLE_ASSERT_SVH
`define DEFERRED_WORK_DEADLINE_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DWDT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dwdt assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DWDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dwdt assertion failed");

`endif

### sv/dwdt_pkg.sv
// Shared types and constants of the deferred-work deadline table.
package dwdt_pkg;

    localparam int DWDT_SLOTS   = 16;
    localparam int TIME_W       = 32;
    localparam int ARG_W        = 32;
    localparam int DELAY_W      = 31;
    localparam int SLOT_FIELD_W = 4;
    localparam int MODE_W       = 2;
    localparam int IN_DATA_W    = 72;
    localparam int OUT_DATA_W   = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_SCHEDULE = 2'd0,
        MODE_CANCEL   = 2'd1,
        MODE_TICK     = 2'd2
    } t_mode;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } t_alu_req;

endpackage

### sv/dwdt_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module dwdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/dwdt_alu.sv
// Shared 32-bit adder and subtractor used for deadlines, the tick count and time compares.
module dwdt_alu import dwdt_pkg::*; (
    input  t_alu_req          i_req,
    output logic [TIME_W-1:0] o_result
);

    always_comb begin
        unique case (i_req.op)
            ALU_ADD: o_result = i_req.a + i_req.b;
            ALU_SUB: o_result = i_req.a - i_req.b;
            default: o_result = i_req.a + i_req.b;
        endcase
    end

endmodule

### sv/deferred_work_deadline_table.sv
// Deferred-work deadline table: SLOTS work slots, each with a pending bit, a deadline and an
// argument, kept in insertion order and fired by timer ticks. The input channel takes one
// transaction at a time and is not ready while one is in progress. A schedule goes through
// S_SCHED_CMP; a cancel of a pending slot or a tick with work pending walks every pending
// slot, while a tick with nothing pending and ignored items stay in idle. A cancel walks the
// order list RAM only; a tick walks it and then the deadline and argument RAMs, each with a
// registered read, into the one shared adder that compares the deadline against the tick
// count; a tick also waits while a fired result cannot be handed on. Fired slots leave in
// insertion order, the last one of a tick marked by tlast. A waiting result sits in an output
// register, so the next transaction is accepted while it is still held. Pending bits are
// flip-flops cleared by reset, so no clearing pass follows reset.
module deferred_work_deadline_table import dwdt_pkg::*; #(
    parameter int SLOTS = DWDT_SLOTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // slot [3:0], argument [35:4], delay_ticks [66:36], zero [71:67]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // mode [1:0]
    input  logic [MODE_W-1:0]     i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // fired_slot [3:0], fired_argument [35:4], zero [39:36]
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_SCHED_CMP = 8'b0000_0010,
        S_TK_LIST   = 8'b0000_0100,
        S_TK_SLOT   = 8'b0000_1000,
        S_TK_EVAL   = 8'b0001_0000,
        S_TK_FLUSH  = 8'b0010_0000,
        S_CN_LIST   = 8'b0100_0000,
        S_CN_CHK    = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [SLOTS-1:0]    r_pending, n_pending;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_rd, n_rd;
    logic [CNT_W-1:0]    r_wr, n_wr;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [TIME_W-1:0]   r_due, n_due;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [ARG_W-1:0]    r_arg, n_arg;
    logic [SLOT_W-1:0]   r_e, n_e;
    logic                r_hold_valid, n_hold_valid;
    logic [SLOT_W-1:0]   r_hold_slot, n_hold_slot;
    logic [ARG_W-1:0]    r_hold_arg, n_hold_arg;
    logic                r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic [ARG_W-1:0]    r_out_arg, n_out_arg;
    logic                r_out_last, n_out_last;

    logic [SLOT_FIELD_W-1:0] in_slot;
    logic [ARG_W-1:0]        in_arg;
    logic [DELAY_W-1:0]      in_delay;
    logic [SLOT_W-1:0]       in_idx;
    logic                    slot_ok;
    logic                    out_free;
    logic                    fire;
    logic                    scan_done;

    t_alu_req            alu_req;
    logic [TIME_W-1:0]   alu_result;

    logic                list_we;
    logic [SLOT_W-1:0]   list_waddr, list_wdata, list_raddr, list_rdata;
    logic                dl_we, arg_we;
    logic [SLOT_W-1:0]   slot_raddr;
    logic [TIME_W-1:0]   dl_rdata;
    logic [ARG_W-1:0]    arg_rdata;

    assign in_slot  = i_s_tdata[3:0];
    assign in_arg   = i_s_tdata[35:4];
    assign in_delay = i_s_tdata[66:36];
    assign in_idx   = SLOT_W'(in_slot);
    assign slot_ok  = ({28'd0, in_slot} < 32'(SLOTS));
    assign out_free = !r_out_valid || i_m_tready;
    assign fire     = alu_result[TIME_W-1];
    assign scan_done = ((r_rd + CNT_ONE) == r_count);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_arg, SLOT_FIELD_W'(r_out_slot)};
    assign o_m_tlast  = r_out_last;

    // Operand selection for the shared adder.
    always_comb begin
        alu_req.op = ALU_ADD;
        alu_req.a  = r_now;
        alu_req.b  = {1'b0, in_delay};
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tuser == MODE_TICK) begin
                    alu_req.b = TIME_W'(1);
                end
            end
            S_SCHED_CMP: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = dl_rdata;
                alu_req.b  = r_due;
            end
            S_TK_EVAL: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = dl_rdata;
                alu_req.b  = r_now;
            end
            default: begin
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    dwdt_alu u_alu (
        .i_req    (alu_req),
        .o_result (alu_result)
    );

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_pending    = r_pending;
        n_count      = r_count;
        n_rd         = r_rd;
        n_wr         = r_wr;
        n_now        = r_now;
        n_due        = r_due;
        n_slot       = r_slot;
        n_arg        = r_arg;
        n_e          = r_e;
        n_hold_valid = r_hold_valid;
        n_hold_slot  = r_hold_slot;
        n_hold_arg   = r_hold_arg;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_slot   = r_out_slot;
        n_out_arg    = r_out_arg;
        n_out_last   = r_out_last;
        list_we      = 1'b0;
        list_waddr   = r_wr[SLOT_W-1:0];
        list_wdata   = list_rdata;
        dl_we        = 1'b0;
        arg_we       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_slot = in_idx;
                    n_arg  = in_arg;
                    n_due  = alu_result;
                    n_rd   = '0;
                    n_wr   = '0;
                    priority if (i_s_tuser == MODE_SCHEDULE) begin
                        if (slot_ok) begin
                            n_state = S_SCHED_CMP;
                        end
                    end else if (i_s_tuser == MODE_CANCEL) begin
                        if (slot_ok && r_pending[in_idx]) begin
                            n_pending[in_idx] = 1'b0;
                            n_state = S_CN_LIST;
                        end
                    end else if (i_s_tuser == MODE_TICK) begin
                        n_now = alu_result;
                        if (r_count != '0) begin
                            n_state = S_TK_LIST;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCHED_CMP: begin
                if (r_pending[r_slot]) begin
                    // Same work again: only an earlier or equal deadline is taken.
                    dl_we = (arg_rdata == r_arg) && !fire;
                end else if (r_count < CNT_W'(SLOTS)) begin
                    dl_we      = 1'b1;
                    arg_we     = 1'b1;
                    list_we    = 1'b1;
                    list_waddr = r_count[SLOT_W-1:0];
                    list_wdata = r_slot;
                    n_pending[r_slot] = 1'b1;
                    n_count    = r_count + CNT_ONE;
                end
                n_state = S_IDLE;
            end
            S_TK_LIST: begin
                n_state = S_TK_SLOT;
            end
            S_TK_SLOT: begin
                n_e     = list_rdata;
                n_state = S_TK_EVAL;
            end
            S_TK_EVAL: begin
                if (!(fire && r_hold_valid && !out_free)) begin
                    if (fire) begin
                        // The held result is not the last one, so it goes out now.
                        if (r_hold_valid) begin
                            n_out_valid = 1'b1;
                            n_out_slot  = r_hold_slot;
                            n_out_arg   = r_hold_arg;
                            n_out_last  = 1'b0;
                        end
                        n_hold_valid   = 1'b1;
                        n_hold_slot    = r_e;
                        n_hold_arg     = arg_rdata;
                        n_pending[r_e] = 1'b0;
                    end else begin
                        list_we    = 1'b1;
                        list_wdata = r_e;
                        n_wr       = r_wr + CNT_ONE;
                    end
                    n_rd    = r_rd + CNT_ONE;
                    n_state = scan_done ? S_TK_FLUSH : S_TK_LIST;
                end
            end
            S_TK_FLUSH: begin
                if (!r_hold_valid) begin
                    n_count = r_wr;
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_slot   = r_hold_slot;
                    n_out_arg    = r_hold_arg;
                    n_out_last   = 1'b1;
                    n_hold_valid = 1'b0;
                    n_count      = r_wr;
                    n_state      = S_IDLE;
                end
            end
            S_CN_LIST: begin
                n_state = S_CN_CHK;
            end
            S_CN_CHK: begin
                n_wr = r_wr;
                if (list_rdata != r_slot) begin
                    list_we = 1'b1;
                    n_wr    = r_wr + CNT_ONE;
                end
                n_rd = r_rd + CNT_ONE;
                if (scan_done) begin
                    n_count = n_wr;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CN_LIST;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign list_raddr = r_rd[SLOT_W-1:0];
    assign slot_raddr = (r_state == S_IDLE) ? in_idx : list_rdata;

    dwdt_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata (list_wdata),
        .i_raddr (list_raddr),
        .o_rdata (list_rdata)
    );

    dwdt_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_deadline_ram (
        .i_clk   (i_clk),
        .i_we    (dl_we),
        .i_waddr (r_slot),
        .i_wdata (r_due),
        .i_raddr (slot_raddr),
        .o_rdata (dl_rdata)
    );

    dwdt_ram #(.WIDTH(ARG_W), .DEPTH(SLOTS)) u_arg_ram (
        .i_clk   (i_clk),
        .i_we    (arg_we),
        .i_waddr (r_slot),
        .i_wdata (r_arg),
        .i_raddr (slot_raddr),
        .o_rdata (arg_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pending    <= '0;
            r_count      <= '0;
            r_rd         <= '0;
            r_wr         <= '0;
            r_now        <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pending    <= n_pending;
            r_count      <= n_count;
            r_rd         <= n_rd;
            r_wr         <= n_wr;
            r_now        <= n_now;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_due       <= n_due;
        r_slot      <= n_slot;
        r_arg       <= n_arg;
        r_e         <= n_e;
        r_hold_slot <= n_hold_slot;
        r_hold_arg  <= n_hold_arg;
        r_out_slot  <= n_out_slot;
        r_out_arg   <= n_out_arg;
        r_out_last  <= n_out_last;
    end

endmodule

### sv/dwdt_checker.sv
// Port-level checker of the deferred-work deadline table and its bind to the top level.
`include "deferred_work_deadline_table_assert.svh"

module dwdt_checker import dwdt_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [IN_DATA_W-1:0]  i_s_tdata,
    input logic [MODE_W-1:0]     i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tlast
);

    // A result waiting for the sink keeps its payload.
    `DWDT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

    // The block only goes busy after taking a transaction.
    `DWDT_ASSERT_SAME(a_busy_after_accept, i_clk, i_rst_n, $fell(o_s_tready), $past(i_s_tvalid) && $past(o_s_tready))

    // New results are only produced while a tick is being worked on.
    `DWDT_ASSERT_SAME(a_result_while_busy, i_clk, i_rst_n, $rose(o_m_tvalid), !$past(o_s_tready))

endmodule

bind deferred_work_deadline_table dwdt_checker u_dwdt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

### verif/tb_top.sv
// Self-checking testbench for the deferred-work deadline table.
`timescale 1ns / 1ps

module tb_top;
    import dwdt_pkg::*;

    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic [SLOT_FIELD_W-1:0] slot;
        logic [ARG_W-1:0]        arg;
        logic                    last;
    } t_fire;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic [MODE_W-1:0]     i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tlast;

    // Timer table as the block should hold it.
    logic              slot_pending [DWDT_SLOTS];
    logic [TIME_W-1:0] slot_deadline [DWDT_SLOTS];
    logic [ARG_W-1:0]  slot_arg [DWDT_SLOTS];
    logic [3:0]        arm_order [DWDT_SLOTS];
    int unsigned       arm_count;
    logic [TIME_W-1:0] tick_count;

    t_fire expected_fires[$];

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int items_sent;
    int ticks_sent;
    int fires_checked;

    deferred_work_deadline_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // a is strictly after b under the wrapping signed compare.
    function automatic logic is_after(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = b - a;
        return diff[TIME_W-1];
    endfunction

    function automatic void predict_timer_item(logic [MODE_W-1:0] mode,
                                               logic [3:0] slot,
                                               logic [ARG_W-1:0] arg,
                                               logic [DELAY_W-1:0] dly);
        logic [TIME_W-1:0] due;
        int unsigned kept;
        int unsigned w;
        t_fire fired[$];
        t_fire f;
        kept = 0;
        case (mode)
            MODE_SCHEDULE: begin
                due = tick_count + {1'b0, dly};
                if (slot_pending[slot]) begin
                    if (slot_arg[slot] == arg && !is_after(due, slot_deadline[slot]))
                        slot_deadline[slot] = due;
                end else if (arm_count < DWDT_SLOTS) begin
                    slot_pending[slot] = 1'b1;
                    slot_arg[slot] = arg;
                    slot_deadline[slot] = due;
                    arm_order[arm_count] = slot;
                    arm_count++;
                end
            end
            MODE_CANCEL: begin
                if (slot_pending[slot]) begin
                    slot_pending[slot] = 1'b0;
                    w = 0;
                    for (int r = 0; r < arm_count; r++) begin
                        if (arm_order[r] != slot) begin
                            arm_order[w] = arm_order[r];
                            w++;
                        end
                    end
                    arm_count = w;
                end
            end
            MODE_TICK: begin
                tick_count = tick_count + 1;
                for (int r = 0; r < arm_count; r++) begin
                    if (is_after(tick_count, slot_deadline[arm_order[r]])) begin
                        slot_pending[arm_order[r]] = 1'b0;
                        f.slot = arm_order[r];
                        f.arg  = slot_arg[arm_order[r]];
                        f.last = 1'b0;
                        fired.push_back(f);
                    end else begin
                        arm_order[kept] = arm_order[r];
                        kept++;
                    end
                end
                arm_count = kept;
                if (fired.size() > 0)
                    fired[fired.size()-1].last = 1'b1;
                foreach (fired[i])
                    expected_fires.push_back(fired[i]);
            end
            default: begin
            end
        endcase
    endfunction

    // Predict on every accepted input and check every accepted result.
    always @(posedge i_clk) begin
        t_fire exp_fire;
        if (i_rst_n && i_s_tvalid && o_s_tready)
            predict_timer_item(i_s_tuser, i_s_tdata[3:0], i_s_tdata[35:4], i_s_tdata[66:36]);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_fires.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual slot %0d arg %h last %0b",
                         $time, o_m_tdata[3:0], o_m_tdata[35:4], o_m_tlast);
                error_count++;
            end else begin
                exp_fire = expected_fires.pop_front();
                fires_checked++;
                if (o_m_tdata[3:0] !== exp_fire.slot) begin
                    $display("%0t: fired_slot mismatch, expected %0d actual %0d",
                             $time, exp_fire.slot, o_m_tdata[3:0]);
                    error_count++;
                end
                if (o_m_tdata[35:4] !== exp_fire.arg) begin
                    $display("%0t: fired_argument mismatch, expected %h actual %h",
                             $time, exp_fire.arg, o_m_tdata[35:4]);
                    error_count++;
                end
                if (o_m_tlast !== exp_fire.last) begin
                    $display("%0t: last mismatch, expected %0b actual %0b",
                             $time, exp_fire.last, o_m_tlast);
                    error_count++;
                end
                if (o_m_tdata[39:36] !== 4'd0) begin
                    $display("%0t: tdata padding mismatch, expected 0 actual %h",
                             $time, o_m_tdata[39:36]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [3:0] slot,
                             input logic [ARG_W-1:0] arg, input logic [DELAY_W-1:0] dly);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'd0, dly, arg, slot};
        i_s_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        items_sent++;
        if (mode == MODE_TICK)
            ticks_sent++;
    endtask

    // The sender holds off until every predicted result has been taken.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        // Waiting on the clock before the check lets the prediction of the last accepted transaction land first.
        @(posedge i_clk);
        while (expected_fires.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_special_cases();
        send_item(MODE_SCHEDULE, 4'd0, 32'h0000_0000, 31'd0);
        send_item(MODE_SCHEDULE, 4'd15, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        // Same argument, earlier deadline: the deadline moves in.
        send_item(MODE_SCHEDULE, 4'd15, 32'hFFFF_FFFF, 31'd3);
        // Same argument, later deadline: no change.
        send_item(MODE_SCHEDULE, 4'd15, 32'hFFFF_FFFF, 31'd9);
        // Different argument on a pending slot is dropped.
        send_item(MODE_SCHEDULE, 4'd15, 32'h1234_5678, 31'd0);
        send_item(MODE_CANCEL, 4'd7, 32'hA5A5_A5A5, 31'd0);
        send_item(MODE_RESERVED, 4'd15, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_item(MODE_TICK, 4'd0, 32'd0, 31'd0);
        send_item(MODE_TICK, 4'd0, 32'd0, 31'd0);
        send_item(MODE_TICK, 4'd0, 32'd0, 31'd0);
        send_item(MODE_TICK, 4'd0, 32'd0, 31'd0);
        // Cancel from the middle of the list must keep the order of the rest.
        send_item(MODE_SCHEDULE, 4'd5, 32'hCAFE_0005, 31'd0);
        send_item(MODE_SCHEDULE, 4'd6, 32'hCAFE_0006, 31'd0);
        send_item(MODE_SCHEDULE, 4'd7, 32'hCAFE_0007, 31'd0);
        send_item(MODE_CANCEL, 4'd6, 32'd0, 31'd0);
        send_item(MODE_TICK, 4'd0, 32'd0, 31'd0);
        send_item(MODE_TICK, 4'd0, 32'd0, 31'd0);
        wait_drained();
    endtask

    // Arm every slot in reverse index order so one tick fires the whole table.
    task automatic test_full_table();
        for (int s = DWDT_SLOTS - 1; s >= 0; s--)
            send_item(MODE_SCHEDULE, s[3:0], $urandom(), 31'd0);
        send_item(MODE_TICK, 4'd0, 32'd0, 31'd0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items);
        int counted;
        int pick;
        logic [MODE_W-1:0] mode;
        logic [3:0] slot;
        logic [ARG_W-1:0] arg;
        logic [DELAY_W-1:0] dly;
        counted = 0;
        while (counted < n_items) begin
            pick = $urandom_range(0, 99);
            slot = 4'($urandom_range(0, DWDT_SLOTS - 1));
            if (pick < 45)
                mode = MODE_SCHEDULE;
            else if (pick < 60)
                mode = MODE_CANCEL;
            else if (pick < 95)
                mode = MODE_TICK;
            else
                mode = MODE_RESERVED;
            // Reuse the stored argument half the time so rescheduling is exercised.
            if (slot_pending[slot] && $urandom_range(0, 1) == 1)
                arg = slot_arg[slot];
            else
                arg = $urandom();
            if ($urandom_range(0, 9) == 0)
                dly = DELAY_W'($urandom());
            else
                dly = DELAY_W'($urandom_range(0, 12));
            send_item(mode, slot, arg, dly);
            if (mode != MODE_RESERVED)
                counted++;
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        items_sent     = 0;
        ticks_sent     = 0;
        fires_checked  = 0;
        arm_count      = 0;
        tick_count     = '0;
        for (int i = 0; i < DWDT_SLOTS; i++) begin
            slot_pending[i]  = 1'b0;
            slot_deadline[i] = '0;
            slot_arg[i]      = '0;
            arm_order[i]     = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_cases();
        test_full_table();

        test_random_traffic(110);
        send_idle_pct = 87;
        test_random_traffic(110);
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        test_random_traffic(110);
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        test_random_traffic(110);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d transactions, %0d of them ticks, and checked %0d fired slots,",
                 items_sent, ticks_sent, fires_checked);
        $display("with directed edge cases, a full table and four idle and stall patterns.");
        if (error_count == 0 && expected_fires.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #8ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
